@@ rtl/hfp_pkg.sv @@
package hfp_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_EOS   = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Packet kinds carried on every output byte
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_LAST   = 2'd3
  } kind_e;

  // Packet emission state, one-hot
  typedef enum logic [7:0] {
    M_IDLE       = 8'b0000_0001,
    M_SINGLE     = 8'b0000_0010,
    M_FIRST_BODY = 8'b0000_0100,
    M_MID_BODY   = 8'b0000_1000,
    M_LAST_BODY  = 8'b0001_0000,
    M_FIRST_HDR  = 8'b0010_0000,
    M_LAST_HDR   = 8'b0100_0000,
    M_NEXT_FRAG  = 8'b1000_0000
  } mode_e;

  localparam logic [7:0]  FU_HDR0           = 8'h62;  // type 49 shifted into NAL header
  localparam logic [7:0]  FU_HDR1           = 8'h01;
  localparam logic [7:0]  FU_S_BIT          = 8'h80;
  localparam logic [7:0]  FU_E_BIT          = 8'h40;
  localparam logic [5:0]  TYPE_MASK         = 6'h3F;
  localparam logic [10:0] PAYLOAD_LIMIT_RST = 11'd1400;
  localparam int          MIN_PAYLOAD       = 4;
  localparam int          LEFT_W            = 11;

  // One output byte with its sideband
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    kind_e      kind;
    logic       done;
  } item_t;

  // Back part reports what it took from the window and the end list
  typedef struct packed {
    logic consume;
    logic end_pop;
  } back_status_t;

endpackage

@@ rtl/hfp_ram.sv @@
module hfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/hfp_cmd_fifo.sv @@
module hfp_cmd_fifo (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output logic data_o
);

  logic [1:0] data_q;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = data_q[rp_q];

  // Hold up to two pop requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) data_q[wp_q] <= data_i;
  end

endmodule

@@ rtl/hfp_front.sv @@
module hfp_front #(
  parameter int WINDOW_BYTES = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         in_action_i,
  input  logic [7:0]                         in_byte_i,
  input  logic [$clog2(WINDOW_BYTES+1)-1:0]  eff_payload_i,
  input  logic                               cmd_full_i,
  output logic                               cmd_push_o,
  output logic                               cmd_done_o,
  output logic                               win_we_o,
  output logic [$clog2(WINDOW_BYTES)-1:0]    win_waddr_o,
  output logic [7:0]                         win_wdata_o,
  output logic                               end_we_o,
  output logic [$clog2(WINDOW_BYTES)-1:0]    end_waddr_o,
  output logic [$clog2(WINDOW_BYTES)-1:0]    end_wdata_o,
  output logic [$clog2(WINDOW_BYTES+1)-1:0]  unread_o,
  output logic [$clog2(WINDOW_BYTES+1)-1:0]  ecount_o,
  output logic                               discard_o,
  input  hfp_pkg::back_status_t              back_i
);

  import hfp_pkg::*;

  localparam int IW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(WINDOW_BYTES + 1);
  localparam logic [CW-1:0] FULL = CW'(WINDOW_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_BYTES - 1);

  logic [CW-1:0] fill_q, fill_d, unread_q, unread_d, ecount_q, ecount_d, fill_p;
  logic [IW-1:0] wr_q, wr_d, last_wr_q, last_wr_d, ewr_q, ewr_d;
  logic [1:0]    zr_q, zr_d;
  logic          seen_q, seen_d, next_nal_q, next_nal_d, ended_q, ended_d;
  logic          popped_q, popped_d;
  action_e       act;
  logic          is_data, is_sc, needs_flush, push_room, flush_go, accept;
  logic          push, write, close, pop, pop_done, discard, data_step, end_we;
  logic [7:0]    push_val;

  // Classify the waiting request
  assign act         = action_e'(in_action_i);
  assign is_data     = (act == ACT_DATA) && !ended_q;
  assign is_sc       = (in_byte_i == 8'h01) && (zr_q >= 2'd2);
  assign needs_flush = (is_data && (in_byte_i != 8'h00) && !is_sc) ||
                       ((act == ACT_EOS) && !ended_q);
  assign push_room   = !((unread_q == FULL) && (fill_q != FULL));
  assign flush_go    = in_valid_i && needs_flush && (zr_q != 2'd0) && push_room;
  assign in_ready_o  = !(needs_flush && (zr_q != 2'd0)) && push_room && !cmd_full_i;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    zr_d      = zr_q;
    seen_d    = seen_q;
    ended_d   = ended_q;
    push      = 1'b0;
    push_val  = 8'h00;
    close     = 1'b0;
    pop       = 1'b0;
    pop_done  = 1'b0;
    discard   = 1'b0;
    data_step = 1'b0;
    if (flush_go) begin
      // Push one pending zero ahead of the waiting request
      push = 1'b1;
      zr_d = zr_q - 2'd1;
    end else if (accept) begin
      case (act)
        ACT_DATA: begin
          if (!ended_q) begin
            data_step = 1'b1;
            if (in_byte_i == 8'h00) begin
              if (zr_q != 2'd3) zr_d = zr_q + 2'd1;
              else push = 1'b1;
            end else if (is_sc) begin
              zr_d   = 2'd0;
              seen_d = 1'b1;
              if (!seen_q && !popped_q) discard = 1'b1;
              else close = 1'b1;
            end else begin
              push     = 1'b1;
              push_val = in_byte_i;
            end
          end
        end
        ACT_EOS: begin
          if (!ended_q) begin
            close   = 1'b1;
            ended_d = 1'b1;
          end
        end
        ACT_DRAIN: begin
          if (ended_q && (fill_q != '0)) begin
            pop      = 1'b1;
            pop_done = (fill_q == CW'(1));
          end
        end
        default: ;
      endcase
    end

    // Window bookkeeping
    write  = push && (fill_q != FULL);
    fill_p = discard ? '0 : fill_q + CW'(write);
    if (data_step && (fill_p > eff_payload_i + CW'(4))) pop = 1'b1;
    fill_d   = fill_p - CW'(pop);
    unread_d = (discard ? '0 : unread_q + CW'(write)) - CW'(back_i.consume);
    wr_d     = discard ? '0 : (write ? ((wr_q == LAST_IDX) ? '0 : wr_q + IW'(1)) : wr_q);
    last_wr_d = write ? wr_q : last_wr_q;

    // Mark the end of the open NAL unit
    end_we   = close && !next_nal_q && (fill_q != '0);
    ecount_d = ecount_q + CW'(end_we) - CW'(back_i.end_pop);
    ewr_d    = end_we ? ((ewr_q == LAST_IDX) ? '0 : ewr_q + IW'(1)) : ewr_q;

    next_nal_d = next_nal_q;
    if (write) next_nal_d = 1'b0;
    if (close || discard) next_nal_d = 1'b1;
    popped_d = popped_q || pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      unread_q   <= '0;
      ecount_q   <= '0;
      wr_q       <= '0;
      last_wr_q  <= '0;
      ewr_q      <= '0;
      zr_q       <= 2'd0;
      seen_q     <= 1'b0;
      next_nal_q <= 1'b1;
      ended_q    <= 1'b0;
      popped_q   <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      unread_q   <= unread_d;
      ecount_q   <= ecount_d;
      wr_q       <= wr_d;
      last_wr_q  <= last_wr_d;
      ewr_q      <= ewr_d;
      zr_q       <= zr_d;
      seen_q     <= seen_d;
      next_nal_q <= next_nal_d;
      ended_q    <= ended_d;
      popped_q   <= popped_d;
    end
  end

  assign win_we_o    = write;
  assign win_waddr_o = wr_q;
  assign win_wdata_o = push_val;
  assign end_we_o    = end_we;
  assign end_waddr_o = ewr_q;
  assign end_wdata_o = last_wr_q;
  assign cmd_push_o  = pop;
  assign cmd_done_o  = pop_done;
  assign unread_o    = unread_q;
  assign ecount_o    = ecount_q;
  assign discard_o   = discard;

endmodule

@@ rtl/hfp_back.sv @@
module hfp_back #(
  parameter int WINDOW_BYTES = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  logic                               cmd_done_i,
  output logic                               cmd_pop_o,
  input  logic [$clog2(WINDOW_BYTES+1)-1:0]  eff_payload_i,
  input  logic [$clog2(WINDOW_BYTES+1)-1:0]  unread_i,
  input  logic [$clog2(WINDOW_BYTES+1)-1:0]  ecount_i,
  input  logic                               discard_i,
  output logic [$clog2(WINDOW_BYTES)-1:0]    win_raddr_o,
  input  logic [7:0]                         win_rdata_i,
  output logic [$clog2(WINDOW_BYTES)-1:0]    end_raddr_o,
  input  logic [$clog2(WINDOW_BYTES)-1:0]    end_rdata_i,
  output hfp_pkg::back_status_t              status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hfp_pkg::item_t                     out_item_o
);

  import hfp_pkg::*;

  localparam int IW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(WINDOW_BYTES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_BYTES - 1);

  logic [IW-1:0]     rd_q, rd_d, erd_q, erd_d;
  logic              byte_ok_q, byte_ok_d, end_ok_q, end_ok_d;
  mode_e             mode_q, mode_d;
  logic [5:0]        type_q, type_d;
  logic [LEFT_W-1:0] left_q, left_d, left_n;
  item_t             burst_q [4];
  item_t             burst_d [4];
  item_t             nb [4];
  logic [2:0]        bcnt_q, bcnt_d, n;
  logic [1:0]        bidx_q, bidx_d;
  item_t             out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out, burst_free, end_known, start, m_last, last;
  logic              consume, end_pop;
  logic [CW-1:0]     rem, len0, len7;
  kind_e             kind;
  logic [7:0]        fu;

  // Length left in the head NAL unit, when its end is known
  always_comb begin
    if (end_rdata_i >= rd_q) rem = CW'(end_rdata_i) - CW'(rd_q) + CW'(1);
    else rem = CW'(WINDOW_BYTES) + CW'(end_rdata_i) - CW'(rd_q) + CW'(1);
  end
  assign m_last    = end_ok_q && (end_rdata_i == rd_q);
  assign len0      = (end_ok_q && (rem <= eff_payload_i + CW'(2))) ? rem : '0;
  assign len7      = (end_ok_q && (rem <= eff_payload_i)) ? rem : '0;
  assign end_known = end_ok_q || (ecount_i == '0);

  assign load_out   = !out_valid_q || out_ready_i;
  assign burst_free = (bcnt_q == 3'd0) || ((bcnt_q == 3'd1) && load_out);
  assign start      = cmd_valid_i && byte_ok_q && end_known && burst_free;

  always_comb begin
    mode_d      = mode_q;
    type_d      = type_q;
    left_d      = left_q;
    left_n      = left_q;
    burst_d     = burst_q;
    bcnt_d      = bcnt_q;
    bidx_d      = bidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    consume     = 1'b0;
    end_pop     = 1'b0;
    n           = 3'd0;
    kind        = KIND_SINGLE;
    fu          = 8'h00;
    last        = 1'b0;
    for (int i = 0; i < 4; i++) nb[i] = '0;

    // Advance the output register from the burst
    if (load_out) begin
      if (bcnt_q != 3'd0) begin
        out_d       = burst_q[bidx_q];
        out_valid_d = 1'b1;
        bidx_d      = bidx_q + 2'd1;
        bcnt_d      = bcnt_q - 3'd1;
      end else begin
        out_valid_d = 1'b0;
      end
    end

    // Carry out one pop request
    if (start) begin
      consume = 1'b1;
      end_pop = m_last;
      case (mode_q)
        M_SINGLE, M_FIRST_BODY, M_MID_BODY, M_LAST_BODY: begin
          if (mode_q == M_SINGLE) kind = KIND_SINGLE;
          else if (mode_q == M_FIRST_BODY) kind = KIND_FIRST;
          else if (mode_q == M_MID_BODY) kind = KIND_MIDDLE;
          else kind = KIND_LAST;
          last  = (left_q <= LEFT_W'(1)) || m_last;
          nb[0] = '{data: win_rdata_i, first: 1'b0, last: last, kind: kind, done: 1'b0};
          n     = 3'd1;
          if (left_q != '0) left_d = left_q - LEFT_W'(1);
          if (last) begin
            mode_d = (((mode_q == M_FIRST_BODY) || (mode_q == M_MID_BODY)) && !m_last) ?
                     M_NEXT_FRAG : M_IDLE;
          end
        end
        M_FIRST_HDR, M_LAST_HDR: begin
          kind  = (mode_q == M_FIRST_HDR) ? KIND_FIRST : KIND_LAST;
          fu    = ((mode_q == M_FIRST_HDR) ? FU_S_BIT : FU_E_BIT) | {2'b00, type_q};
          nb[0] = '{data: FU_HDR1, first: 1'b0, last: 1'b0, kind: kind, done: 1'b0};
          nb[1] = '{data: fu, first: 1'b0, last: 1'b0, kind: kind, done: 1'b0};
          n     = 3'd2;
          mode_d = (mode_q == M_FIRST_HDR) ? M_FIRST_BODY : M_LAST_BODY;
        end
        M_NEXT_FRAG: begin
          if (len7 != '0) begin
            kind   = KIND_LAST;
            fu     = FU_E_BIT | {2'b00, type_q};
            left_n = LEFT_W'(len7);
          end else begin
            kind   = KIND_MIDDLE;
            fu     = {2'b00, type_q};
            left_n = LEFT_W'(eff_payload_i);
          end
          last  = (left_n <= LEFT_W'(1)) || m_last;
          nb[0] = '{data: FU_HDR0, first: 1'b1, last: 1'b0, kind: kind, done: 1'b0};
          nb[1] = '{data: FU_HDR1, first: 1'b0, last: 1'b0, kind: kind, done: 1'b0};
          nb[2] = '{data: fu, first: 1'b0, last: 1'b0, kind: kind, done: 1'b0};
          nb[3] = '{data: win_rdata_i, first: 1'b0, last: last, kind: kind, done: 1'b0};
          n     = 3'd4;
          left_d = left_n - LEFT_W'(1);
          if (last) mode_d = ((kind == KIND_MIDDLE) && !m_last) ? M_NEXT_FRAG : M_IDLE;
          else mode_d = (kind == KIND_LAST) ? M_LAST_BODY : M_MID_BODY;
        end
        default: begin
          if ((len0 != '0) && (len0 <= eff_payload_i)) begin
            left_d = LEFT_W'(len0 - CW'(1));
            nb[0]  = '{data: win_rdata_i, first: 1'b1, last: (len0 == CW'(1)),
                       kind: KIND_SINGLE, done: 1'b0};
            mode_d = (len0 != CW'(1)) ? M_SINGLE : M_IDLE;
          end else begin
            type_d = win_rdata_i[6:1] & TYPE_MASK;
            if (len0 != '0) begin
              left_d = LEFT_W'(len0 - CW'(2));
              nb[0]  = '{data: FU_HDR0, first: 1'b1, last: 1'b0, kind: KIND_LAST,
                         done: 1'b0};
              mode_d = M_LAST_HDR;
            end else begin
              left_d = LEFT_W'(eff_payload_i);
              nb[0]  = '{data: FU_HDR0, first: 1'b1, last: 1'b0, kind: KIND_FIRST,
                         done: 1'b0};
              mode_d = M_FIRST_HDR;
            end
          end
          n = 3'd1;
        end
      endcase
      nb[2'(n - 3'd1)].done = cmd_done_i;
      burst_d = nb;
      bcnt_d  = n;
      bidx_d  = 2'd0;
    end

    // Step the read pointers and judge the next read
    rd_d      = consume ? ((rd_q == LAST_IDX) ? '0 : rd_q + IW'(1)) : rd_q;
    erd_d     = end_pop ? ((erd_q == LAST_IDX) ? '0 : erd_q + IW'(1)) : erd_q;
    byte_ok_d = !discard_i && (consume ? (unread_i > CW'(1)) : (unread_i != '0));
    end_ok_d  = end_pop ? (ecount_i > CW'(1)) : (ecount_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      erd_q       <= '0;
      byte_ok_q   <= 1'b0;
      end_ok_q    <= 1'b0;
      mode_q      <= M_IDLE;
      type_q      <= 6'd0;
      left_q      <= '0;
      bcnt_q      <= 3'd0;
      bidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      rd_q        <= rd_d;
      erd_q       <= erd_d;
      byte_ok_q   <= byte_ok_d;
      end_ok_q    <= end_ok_d;
      mode_q      <= mode_d;
      type_q      <= type_d;
      left_q      <= left_d;
      bcnt_q      <= bcnt_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
    out_q   <= out_d;
  end

  assign cmd_pop_o        = start;
  assign win_raddr_o      = rd_d;
  assign end_raddr_o      = erd_d;
  assign status_o.consume = consume;
  assign status_o.end_pop = end_pop;
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;

endmodule

@@ rtl/hevc_annexb_fu_packetizer_core.sv @@
// Annex B to fragmentation-unit packetizer. Stream bytes enter on the slave
// side at one per cycle while s_axis_tready is high; a byte that follows a
// run of pending zeros (up to three) is held while those zeros are written
// into the window. Each byte that leaves the window yields one to four packet
// bytes on the master side, which leaves one byte per cycle while the sink is
// ready, so the input rate follows the output rate once the window holds more
// than the payload limit plus four bytes; fragment headers and the read of
// the next end position from the end list memory at a NAL boundary hold the
// input further. The window and the end list are single-port-write memories
// of WINDOW_BYTES entries; a two-entry request queue separates the byte
// classifier from the packet builder. The payload limit is taken at the next
// packet and is clamped to 4 .. WINDOW_BYTES-10.
module hevc_annexb_fu_packetizer_core #(
  parameter int WINDOW_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [3:0]  m_axis_tuser,   // [0] packet_first, [2:1] packet_kind, [3] stream_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  import hfp_pkg::*;

  localparam int IW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(WINDOW_BYTES + 1);
  localparam int EW = (CW > 11) ? CW : 11;

  logic [10:0]   pkt_limit_q;
  logic [EW-1:0] cfg_x, eff_x;
  logic [CW-1:0] eff, unread, ecount;
  logic          cmd_full, cmd_push, cmd_done_in, cmd_valid, cmd_done, cmd_pop;
  logic          win_we, end_we, discard;
  logic [IW-1:0] win_waddr, win_raddr, end_waddr, end_raddr, end_wdata, end_rdata;
  logic [7:0]    win_wdata, win_rdata;
  back_status_t  back_st;
  item_t         out_item;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pkt_limit_q <= PAYLOAD_LIMIT_RST;
    else if (cfg_valid_i) pkt_limit_q <= cfg_data_i;
  end

  // Clamp the payload size
  always_comb begin
    cfg_x = EW'(pkt_limit_q);
    if (cfg_x < EW'(MIN_PAYLOAD)) eff_x = EW'(MIN_PAYLOAD);
    else if (cfg_x > EW'(WINDOW_BYTES - 10)) eff_x = EW'(WINDOW_BYTES - 10);
    else eff_x = cfg_x;
  end
  assign eff = CW'(eff_x);

  hfp_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .eff_payload_i (eff),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_done_o    (cmd_done_in),
    .win_we_o      (win_we),
    .win_waddr_o   (win_waddr),
    .win_wdata_o   (win_wdata),
    .end_we_o      (end_we),
    .end_waddr_o   (end_waddr),
    .end_wdata_o   (end_wdata),
    .unread_o      (unread),
    .ecount_o      (ecount),
    .discard_o     (discard),
    .back_i        (back_st)
  );

  hfp_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_done_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_done)
  );

  hfp_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  hfp_ram #(.WIDTH(IW), .DEPTH(WINDOW_BYTES)) u_ends (
    .clk_i   (clk_i),
    .we_i    (end_we),
    .waddr_i (end_waddr),
    .wdata_i (end_wdata),
    .raddr_i (end_raddr),
    .rdata_o (end_rdata)
  );

  hfp_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_done_i    (cmd_done),
    .cmd_pop_o     (cmd_pop),
    .eff_payload_i (eff),
    .unread_i      (unread),
    .ecount_i      (ecount),
    .discard_i     (discard),
    .win_raddr_o   (win_raddr),
    .win_rdata_i   (win_rdata),
    .end_raddr_o   (end_raddr),
    .end_rdata_i   (end_rdata),
    .status_o      (back_st),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_item_o    (out_item)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tlast = out_item.last;
  assign m_axis_tuser = {out_item.done, out_item.kind, out_item.first};

endmodule

@@ verif/hfp_scoreboard.sv @@
`timescale 1ns / 100ps

// Watches the stream, config and packet channels, predicts the packet bytes
// and compares them in order against what the block delivers.
module hfp_scoreboard #(
  parameter int WINDOW_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  output int          mismatch_cnt_o,
  output int          pending_o,
  output int          held_o
);

  import hfp_pkg::*;

  localparam int PAYLOAD_CAP = WINDOW_BYTES - 10;

  logic [10:0] payload_reg;
  logic [7:0]  win_data [WINDOW_BYTES];
  logic [1:0]  win_mark [WINDOW_BYTES];
  int          fill;
  int          head;
  int          zero_cnt;
  bit          synced;
  bit          open_next;
  bit          ended;
  logic [5:0]  type_held;
  int          bytes_left;
  mode_e       mode;
  item_t       pkt_bytes_q[$];
  int          mismatches;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = pkt_bytes_q.size();
  assign held_o         = fill;

  function automatic int payload_eff();
    int v;
    v = payload_reg;
    if (v < MIN_PAYLOAD) v = MIN_PAYLOAD;
    if (v > PAYLOAD_CAP) v = PAYLOAD_CAP;
    return v;
  endfunction

  function automatic int slot(int i);
    int idx;
    idx = head + i;
    if (idx >= WINDOW_BYTES) idx -= WINDOW_BYTES;
    return idx;
  endfunction

  function automatic void push_win(logic [7:0] b);
    int idx;
    if (fill >= WINDOW_BYTES) return;
    idx = slot(fill);
    win_data[idx] = b;
    win_mark[idx] = open_next ? 2'b01 : 2'b00;
    open_next = 1'b0;
    fill++;
  endfunction

  function automatic void flush_zeros();
    while (zero_cnt > 0) begin
      push_win(8'h00);
      zero_cnt--;
    end
  endfunction

  function automatic void close_unit();
    if (!open_next && fill > 0) win_mark[slot(fill - 1)][1] = 1'b1;
    open_next = 1'b1;
  endfunction

  // Length of the NAL at the head if it ends within lim bytes, else 0
  function automatic int end_within(int lim);
    for (int i = 0; i < lim && i < fill; i++)
      if (win_mark[slot(i)][1]) return i + 1;
    return 0;
  endfunction

  function automatic void emit(logic [7:0] b, bit f, bit l, kind_e k);
    item_t it;
    it.data  = b;
    it.first = f;
    it.last  = l;
    it.kind  = k;
    it.done  = 1'b0;
    pkt_bytes_q.insert(pkt_bytes_q.size(), it);
  endfunction

  // Take one byte off the window head and build its packet bytes
  function automatic void pop_window();
    int         mp;
    int         len;
    logic [7:0] b;
    logic [1:0] m;
    bit         l;
    kind_e      k;
    logic [7:0] fu;
    mp  = payload_eff();
    len = 0;
    if (fill == 0) return;
    if (mode == M_IDLE) len = end_within(mp + 2);
    else if (mode == M_NEXT_FRAG) len = end_within(mp);
    b = win_data[head];
    m = win_mark[head];
    win_mark[head] = 2'b00;
    head = slot(1);
    fill--;
    case (mode)
      M_SINGLE, M_FIRST_BODY, M_MID_BODY, M_LAST_BODY: begin
        k = (mode == M_SINGLE) ? KIND_SINGLE : (mode == M_FIRST_BODY) ? KIND_FIRST :
            (mode == M_MID_BODY) ? KIND_MIDDLE : KIND_LAST;
        l = (bytes_left <= 1) || m[1];
        emit(b, 1'b0, l, k);
        if (bytes_left > 0) bytes_left--;
        if (l)
          mode = ((mode == M_FIRST_BODY || mode == M_MID_BODY) && !m[1]) ? M_NEXT_FRAG
                                                                          : M_IDLE;
      end
      M_FIRST_HDR, M_LAST_HDR: begin
        k  = (mode == M_FIRST_HDR) ? KIND_FIRST : KIND_LAST;
        fu = (mode == M_FIRST_HDR) ? FU_S_BIT : FU_E_BIT;
        emit(FU_HDR1, 1'b0, 1'b0, k);
        emit(fu | {2'b00, type_held}, 1'b0, 1'b0, k);
        mode = (mode == M_FIRST_HDR) ? M_FIRST_BODY : M_LAST_BODY;
      end
      M_NEXT_FRAG: begin
        if (len != 0) begin
          k = KIND_LAST;
          fu = FU_E_BIT | {2'b00, type_held};
          bytes_left = len;
        end else begin
          k = KIND_MIDDLE;
          fu = {2'b00, type_held};
          bytes_left = mp;
        end
        emit(FU_HDR0, 1'b1, 1'b0, k);
        emit(FU_HDR1, 1'b0, 1'b0, k);
        emit(fu, 1'b0, 1'b0, k);
        l = (bytes_left <= 1) || m[1];
        emit(b, 1'b0, l, k);
        bytes_left--;
        if (l) mode = (k == KIND_MIDDLE && !m[1]) ? M_NEXT_FRAG : M_IDLE;
        else mode = (k == KIND_LAST) ? M_LAST_BODY : M_MID_BODY;
      end
      default: begin
        if (len != 0 && len <= mp) begin
          bytes_left = len - 1;
          emit(b, 1'b1, len == 1, KIND_SINGLE);
          mode = (bytes_left != 0) ? M_SINGLE : M_IDLE;
        end else begin
          type_held = b[6:1] & TYPE_MASK;
          if (len != 0) begin
            bytes_left = len - 2;
            emit(FU_HDR0, 1'b1, 1'b0, KIND_LAST);
            mode = M_LAST_HDR;
          end else begin
            bytes_left = mp;
            emit(FU_HDR0, 1'b1, 1'b0, KIND_FIRST);
            mode = M_FIRST_HDR;
          end
        end
      end
    endcase
  endfunction

  // Advance the prediction by one stream request
  function automatic void take_request(action_e act, logic [7:0] b);
    int n0;
    case (act)
      ACT_DATA: begin
        if (ended) return;
        if (b == 8'h00) begin
          if (zero_cnt < 3) zero_cnt++;
          else push_win(8'h00);
        end else if (b == 8'h01 && zero_cnt >= 2) begin
          zero_cnt = 0;
          if (!synced && mode == M_IDLE) begin
            // drop leading bytes that never left
            foreach (win_mark[i]) win_mark[i] = 2'b00;
            fill = 0;
            head = 0;
            open_next = 1'b1;
          end else begin
            close_unit();
          end
          synced = 1'b1;
        end else begin
          flush_zeros();
          push_win(b);
        end
        if (fill > payload_eff() + 4) pop_window();
      end
      ACT_EOS: begin
        if (ended) return;
        flush_zeros();
        close_unit();
        ended = 1'b1;
      end
      ACT_DRAIN: begin
        if (!ended || fill == 0) return;
        n0 = pkt_bytes_q.size();
        pop_window();
        if (fill == 0 && pkt_bytes_q.size() > n0) pkt_bytes_q[$].done = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Compare one delivered packet byte with the oldest prediction
  function automatic void check_byte();
    item_t want;
    item_t got;
    got.data  = m_axis_tdata;
    got.first = m_axis_tuser[0];
    got.last  = m_axis_tlast;
    got.kind  = kind_e'(m_axis_tuser[2:1]);
    got.done  = m_axis_tuser[3];
    if (pkt_bytes_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected packet byte data=%h first=%b last=%b kind=%0d done=%b",
                 $time, got.data, got.first, got.last, got.kind, got.done);
      return;
    end
    want = pkt_bytes_q.pop_front();
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: packet byte mismatch exp data=%h f=%b l=%b k=%0d d=%b,",
                  " got data=%h f=%b l=%b k=%0d d=%b"},
                 $time, want.data, want.first, want.last, want.kind, want.done,
                 got.data, got.first, got.last, got.kind, got.done);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_reg = PAYLOAD_LIMIT_RST;
      foreach (win_mark[i]) win_mark[i] = 2'b00;
      foreach (win_data[i]) win_data[i] = 8'h00;
      fill       = 0;
      head       = 0;
      zero_cnt   = 0;
      synced     = 1'b0;
      open_next  = 1'b1;
      ended      = 1'b0;
      type_held  = '0;
      bytes_left = 0;
      mode       = M_IDLE;
      mismatches = 0;
      pkt_bytes_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_byte();
      if (cfg_valid_i && cfg_ready_o) payload_reg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        take_request(action_e'(s_axis_tuser), s_axis_tdata);
    end
  end

endmodule

@@ verif/hevc_annexb_fu_packetizer_core_tb.sv @@
`timescale 1ns / 100ps

module hevc_annexb_fu_packetizer_core_tb;
  import hfp_pkg::*;

  localparam int WINDOW_BYTES = 2048;
  localparam int SETTLE       = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;

  int   mismatch_cnt;
  int   pending;
  int   held;
  int   tx_idle;
  int   rx_idle;
  int   req_cnt;
  int   unit_cnt;
  int   cur_payload;
  logic hold_req;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  hevc_annexb_fu_packetizer_core #(.WINDOW_BYTES(WINDOW_BYTES)) DUT (.*);

  hfp_scoreboard #(.WINDOW_BYTES(WINDOW_BYTES)) u_scoreboard (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .mismatch_cnt_o(mismatch_cnt), .pending_o(pending), .held_o(held)
  );

  always #5 clk_i = ~clk_i;

  // Packet sink: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt      <= 400;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("hevc_annexb_fu_packetizer_core_tb: errors");
    $finish;
  end

  // Offer one stream request after a random gap and hold it until taken
  task automatic send_req(input action_e act, input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    req_cnt++;
  endtask

  task automatic send_bytes(input logic [7:0] b[$]);
    foreach (b[i]) send_req(ACT_DATA, b[i]);
  endtask

  // Drop valid and wait until every predicted packet byte has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_payload(input logic [10:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_payload = (v < MIN_PAYLOAD) ? MIN_PAYLOAD : v;
  endtask

  // Start code then a NAL of random content
  task automatic send_unit(input int len);
    if ($urandom_range(1)) send_req(ACT_DATA, 8'h00);
    send_bytes('{8'h00, 8'h00, 8'h01});
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       send_req(ACT_DATA, 8'h00);
        1:       send_req(ACT_DATA, 8'h01);
        default: send_req(ACT_DATA, 8'($urandom_range(255)));
      endcase
    end
    unit_cnt++;
  endtask

  // Mostly well-formed NAL units, some noise and broken start codes
  task automatic random_phase(input int n_req, input bit do_hold, input bit do_pause);
    int stop;
    stop = req_cnt + n_req;
    while (req_cnt < stop) begin
      if (do_hold && req_cnt > stop - n_req / 2) hold_req <= 1'b1;
      if (do_pause && req_cnt > stop - n_req / 2) begin
        wait_drained();
        do_pause = 1'b0;
      end
      case ($urandom_range(9))
        0: send_req(action_e'($urandom_range(1) ? ACT_NONE : ACT_DRAIN),
                    8'($urandom_range(255)));
        1: send_bytes('{8'h00, 8'h00, 8'($urandom_range(2, 255))});
        2: send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        default: send_unit($urandom_range(1, 2 * cur_payload + 6));
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_DATA;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    tx_idle       = 0;
    rx_idle       = 0;
    req_cnt       = 0;
    unit_cnt      = 0;
    cur_payload   = PAYLOAD_LIMIT_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest payload, leading bytes, both start code lengths,
    // empty NAL, single packet, end-only fragment, split NAL, long zero run
    write_payload(11'd4);
    send_bytes('{8'h02, 8'h03, 8'h00, 8'h00, 8'h01});
    send_bytes('{8'h40, 8'h01, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h01});
    send_bytes('{8'h00, 8'h00, 8'h01});
    send_bytes('{8'h26, 8'h01, 8'haa, 8'hbb, 8'hcc, 8'h00, 8'h00, 8'h01});
    send_bytes('{8'hfe, 8'h01, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'hff});
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7e});
    send_req(ACT_NONE, 8'h5a);
    send_req(ACT_DRAIN, 8'ha5);

    tx_idle = 23;
    rx_idle = 66;
    write_payload(11'($urandom_range(5, 12)));
    random_phase(30, 1'b1, 1'b0);

    tx_idle = 66;
    rx_idle = 23;
    write_payload(11'd0);
    random_phase(20, 1'b0, 1'b1);

    tx_idle = 0;
    rx_idle = 0;
    write_payload(11'($urandom_range(4, 24)));
    random_phase(14, 1'b0, 1'b0);

    // Largest payload, trailing zeros, then end of stream and drain
    write_payload(11'd2047);
    send_unit(12);
    send_unit(3);
    send_bytes('{8'h00, 8'h00});
    send_req(ACT_EOS, 8'h00);
    send_req(ACT_DATA, 8'h33);
    send_req(ACT_EOS, 8'h00);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (held != 0) begin
      @(posedge clk_i);
      send_req(ACT_DRAIN, 8'($urandom_range(255)));
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    @(posedge clk_i);
    send_req(ACT_DRAIN, 8'h00);
    s_axis_tvalid <= 1'b0;

    for (int i = 0; i < 5000 && pending != 0; i++) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d stream requests, %0d NAL units, payload sizes 0 to 2047,",
             req_cnt, unit_cnt);
    $display("long sink hold-off, end of stream and full drain.");
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("hevc_annexb_fu_packetizer_core_tb: clean");
    end else begin
      if (pending != 0) $display("%0d predicted packet bytes never arrived", pending);
      $display("hevc_annexb_fu_packetizer_core_tb: errors");
    end
    $finish;
  end

endmodule
